@@ src/lsps_pkg.sv @@
// ----------------------------------------------------------------------------
// lsps_pkg
// Shared codes, reset values and types for the light sensor poll sequencer.
// ----------------------------------------------------------------------------
package lsps_pkg;

  // Field widths
  localparam int ACT_W  = 2;
  localparam int OP_W   = 2;
  localparam int ADDR_W = 7;
  localparam int BYTE_W = 8;
  localparam int ST_W   = 3;
  localparam int VAL_W  = 16;
  localparam int TICK_W = 16;
  localparam int CIDX_W = 2;
  localparam int CDAT_W = 16;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_RUN  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK = 2'd1;
  localparam logic [ACT_W-1:0] ACT_INIT = 2'd2;

  // Bus operation codes
  localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Sequencer state codes
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_LOAD = 3'd1;
  localparam logic [ST_W-1:0] ST_WAIT = 3'd2;
  localparam logic [ST_W-1:0] ST_CONV = 3'd3;
  localparam logic [ST_W-1:0] ST_ERR  = 3'd4;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_DEV_ADDR  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_OP_MODE   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MODE_TMO  = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_MEAS_TMO  = 2'd3;

  // Register reset values
  localparam logic [ADDR_W-1:0] RST_DEV_ADDR = 7'd35;
  localparam logic [BYTE_W-1:0] RST_OP_MODE  = 8'd16;
  localparam logic [TICK_W-1:0] RST_MODE_TMO = 16'd180;
  localparam logic [TICK_W-1:0] RST_MEAS_TMO = 16'd120;

  // Modes below this are continuous
  localparam logic [BYTE_W-1:0] CONT_LIMIT = 8'h20;

  // raw*10/12 = (raw*5)/6; /6 done as *ceil(2^20/6) >> 20, exact below 2^19
  localparam int SCALE_SUM_W = 19;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_6 = 18'd174763;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ST_W-1:0]   state_t;
  typedef logic [VAL_W-1:0]  value_t;
  typedef logic [TICK_W-1:0] tick_t;

  typedef struct packed {
    addr_t device_address;
    byte_t operation_mode;
    tick_t mode_set_timeout;
    tick_t measurement_timeout;
  } cfg_t;

  typedef struct packed {
    state_t pending_state;
    state_t entered_state;
    value_t last_value;
    tick_t  ticks_remaining;
  } seq_state_t;

  typedef struct packed {
    action_t action;
    logic    bus_ok;
    value_t  read_data;
  } item_t;

  typedef struct packed {
    op_t    bus_op;
    addr_t  bus_address;
    byte_t  bus_byte;
    state_t state_code;
    value_t lux;
    logic   lux_valid;
    logic   failed;
  } result_t;

endpackage

@@ src/lsps_in_if.sv @@
// ----------------------------------------------------------------------------
// lsps_in_if
// Input event channel: valid/ready with action, bus status and read bytes.
// ----------------------------------------------------------------------------
interface lsps_in_if;
  logic               valid;
  logic               ready;
  lsps_pkg::action_t  action;
  logic               bus_ok;
  lsps_pkg::value_t   read_data;

  modport source (output valid, output action, output bus_ok, output read_data,
                  input ready);
  modport sink   (input valid, input action, input bus_ok, input read_data,
                  output ready);
endinterface

@@ src/lsps_out_if.sv @@
// ----------------------------------------------------------------------------
// lsps_out_if
// Result channel: valid/ready with bus action, state and lux fields.
// ----------------------------------------------------------------------------
interface lsps_out_if;
  logic              valid;
  logic              ready;
  lsps_pkg::op_t     bus_op;
  lsps_pkg::addr_t   bus_address;
  lsps_pkg::byte_t   bus_byte;
  lsps_pkg::state_t  state_code;
  lsps_pkg::value_t  lux;
  logic              lux_valid;
  logic              failed;

  modport source (output valid, output bus_op, output bus_address, output bus_byte,
                  output state_code, output lux, output lux_valid, output failed,
                  input ready);
  modport sink   (input valid, input bus_op, input bus_address, input bus_byte,
                  input state_code, input lux, input lux_valid, input failed,
                  output ready);
endinterface

@@ src/lsps_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lsps_cfg_regs
// Configuration register file: address, mode byte and the two timeouts.
// ----------------------------------------------------------------------------
module lsps_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lsps_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [lsps_pkg::CDAT_W-1:0]         cfg_data,
  output lsps_pkg::cfg_t                      cfg
);
  import lsps_pkg::*;

  // register writes, low bits of the data word
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address      <= RST_DEV_ADDR;
      cfg.operation_mode      <= RST_OP_MODE;
      cfg.mode_set_timeout    <= RST_MODE_TMO;
      cfg.measurement_timeout <= RST_MEAS_TMO;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEV_ADDR: cfg.device_address      <= cfg_data[ADDR_W-1:0];
        CFG_OP_MODE:  cfg.operation_mode      <= cfg_data[BYTE_W-1:0];
        CFG_MODE_TMO: cfg.mode_set_timeout    <= cfg_data[TICK_W-1:0];
        CFG_MEAS_TMO: cfg.measurement_timeout <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/lsps_step.sv @@
// ----------------------------------------------------------------------------
// lsps_step
// Combinational step: applies one event to the sequencer state and forms
// the result fields.
// ----------------------------------------------------------------------------
module lsps_step (
  input  lsps_pkg::cfg_t       cfg,
  input  lsps_pkg::seq_state_t cur,
  input  lsps_pkg::item_t      item,
  output lsps_pkg::seq_state_t nxt,
  output lsps_pkg::result_t    res
);
  import lsps_pkg::*;

  logic                                    entry;
  logic [SCALE_SUM_W-1:0]                  raw_x5;
  logic [SCALE_SUM_W+RECIP_W-1:0]          prod;
  value_t                                  scaled;
  op_t                                     op;
  logic                                    valid;
  logic                                    fail;

  // lux scaling: raw*5, then divide by 6 through the reciprocal
  assign raw_x5 = {1'b0, cur.last_value, 2'b00} + {3'b000, cur.last_value};
  assign prod   = raw_x5 * RECIP_6;
  assign scaled = prod[RECIP_SHIFT+VAL_W-1:RECIP_SHIFT];

  assign entry = (cur.pending_state != cur.entered_state);

  // next state and step flags
  always_comb begin
    nxt   = cur;
    op    = OP_NONE;
    valid = 1'b0;
    fail  = 1'b0;
    case (item.action)
      ACT_TICK: begin
        if (cur.ticks_remaining != '0) nxt.ticks_remaining = cur.ticks_remaining - 1'b1;
      end
      ACT_INIT: begin
        if (item.bus_ok) nxt.pending_state = ST_LOAD;
        else fail = 1'b1;
      end
      ACT_RUN: begin
        case (cur.pending_state)
          ST_LOAD: begin
            if (entry) begin
              if (item.bus_ok) begin
                nxt.entered_state = ST_LOAD;
              end else begin
                nxt.pending_state = ST_ERR;
                fail = 1'b1;
              end
            end else begin
              op = OP_WRITE;
              if (item.bus_ok) begin
                nxt.ticks_remaining = cfg.mode_set_timeout;
                nxt.pending_state   = ST_WAIT;
              end else begin
                nxt.pending_state = ST_ERR;
                fail = 1'b1;
              end
            end
          end
          ST_WAIT: begin
            if (entry) begin
              nxt.entered_state = ST_WAIT;
            end else if (cur.ticks_remaining == '0) begin
              op = OP_READ;
              if (item.bus_ok) begin
                nxt.last_value    = item.read_data;
                nxt.pending_state = ST_CONV;
              end else begin
                nxt.pending_state = ST_ERR;
                fail = 1'b1;
              end
            end
          end
          ST_CONV: begin
            if (entry) begin
              nxt.entered_state = ST_CONV;
            end else begin
              nxt.last_value = scaled;
              valid = 1'b1;
              if (cfg.operation_mode < CONT_LIMIT) begin
                nxt.ticks_remaining = cfg.measurement_timeout;
                nxt.pending_state   = ST_WAIT;
              end else begin
                nxt.pending_state = ST_LOAD;
              end
            end
          end
          default: begin
            // idle, error and unused codes only adopt the state on entry
            if (entry) nxt.entered_state = cur.pending_state;
          end
        endcase
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    res.bus_op      = op;
    res.bus_address = (op != OP_NONE) ? cfg.device_address : '0;
    res.bus_byte    = (op == OP_WRITE) ? cfg.operation_mode : '0;
    res.state_code  = nxt.pending_state;
    res.lux         = nxt.last_value;
    res.lux_valid   = valid;
    res.failed      = fail;
  end

endmodule

@@ src/light_sensor_poll_sequencer.sv @@
// ----------------------------------------------------------------------------
// light_sensor_poll_sequencer
// Polls an ambient light sensor over a two-wire bus, one event per transfer.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    action, bus_ok, read_data
//  out_ch    out   valid/ready    bus_op, bus_address, bus_byte, state_code,
//                                 lux, lux_valid, failed
//  cfg       in    cfg_we only    cfg_index, cfg_data
//
//  Each event lands in the input register at its transfer; the step logic
//  loads the result register when that register is empty or being taken, and
//  the result is offered on out_ch from the result register.
//  One event per cycle sustained while out_ch.ready holds.
//  Sequencer state updates when an event moves into the result register.
//  A stalled result holds the input register; in_ch.ready drops only then.
//  Synchronous reset restores state and configuration, clears both valid flags.
// ----------------------------------------------------------------------------
module light_sensor_poll_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  lsps_in_if.sink                       in_ch,
  lsps_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [lsps_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [lsps_pkg::CDAT_W-1:0]   cfg_data
);
  import lsps_pkg::*;

  cfg_t       cfg;
  seq_state_t st;
  seq_state_t st_next;
  item_t      item;
  logic       item_valid;
  result_t    res_next;
  result_t    res;
  logic       res_valid;
  logic       advance;

  lsps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsps_step u_step (
    .cfg  (cfg),
    .cur  (st),
    .item (item),
    .nxt  (st_next),
    .res  (res_next)
  );

  // pipeline control
  assign advance     = item_valid && (!res_valid || out_ch.ready);
  assign in_ch.ready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.action    <= in_ch.action;
      item.bus_ok    <= in_ch.bus_ok;
      item.read_data <= in_ch.read_data;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.pending_state   <= ST_IDLE;
      st.entered_state   <= ST_IDLE;
      st.last_value      <= '0;
      st.ticks_remaining <= RST_MODE_TMO;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.bus_op      = res.bus_op;
  assign out_ch.bus_address = res.bus_address;
  assign out_ch.bus_byte    = res.bus_byte;
  assign out_ch.state_code  = res.state_code;
  assign out_ch.lux         = res.lux;
  assign out_ch.lux_valid   = res.lux_valid;
  assign out_ch.failed      = res.failed;

endmodule

@@ dv/tb_light_sensor_poll_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_light_sensor_poll_sequencer
// Self-checking bench for the light sensor poll sequencer. A cycle-free model
// of the sequencer predicts one result per accepted event; a checker compares
// every result transfer field by field against the oldest prediction. Directed
// tests walk the continuous and single-shot poll cycles and the error paths,
// then randomized phases run mostly well-formed poll traffic under several
// register settings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_light_sensor_poll_sequencer;
  import lsps_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RST_CYCLES      = 8;
  localparam int DRAIN_CYCLES    = 4;
  localparam int HOLD_CYCLES     = 100;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int RANDOM_PHASES   = 10;
  localparam int PHASE_EVENTS    = 145;
  localparam int LONG_TMO_EVENTS = 40;
  localparam int LONG_TMO_PHASE  = 4;
  localparam int PRESSURE_EVENTS = 24;
  localparam int unsigned LUX_MUL = 10;
  localparam int unsigned LUX_DIV = 12;
  localparam action_t ACT_UNUSED = 2'd3;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CIDX_W-1:0]   cfg_index;
  logic [CDAT_W-1:0]   cfg_data;

  lsps_in_if  in_ch ();
  lsps_out_if out_ch ();

  light_sensor_poll_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model copy of the registers and the sequencer state
  addr_t   cfg_addr;
  byte_t   cfg_mode;
  tick_t   cfg_mode_tmo;
  tick_t   cfg_meas_tmo;
  state_t  seq_pend;
  state_t  seq_entered;
  value_t  seq_lux;
  tick_t   seq_ticks;

  result_t step_results_q[$];

  int n_events    = 0;
  int n_results   = 0;
  int n_lux       = 0;
  int n_failed    = 0;
  int n_settings  = 0;
  int n_errors    = 0;
  int quiet_cycles = 0;

  bit gaps_on  = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_req = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Sequencer model
  // --------------------------------------------------------------------------
  function automatic void reset_poll_model();
    cfg_addr     = RST_DEV_ADDR;
    cfg_mode     = RST_OP_MODE;
    cfg_mode_tmo = RST_MODE_TMO;
    cfg_meas_tmo = RST_MEAS_TMO;
    seq_pend     = ST_IDLE;
    seq_entered  = ST_IDLE;
    seq_lux      = '0;
    seq_ticks    = RST_MODE_TMO;
  endfunction

  function automatic result_t predict_poll_step(item_t ev);
    result_t     r;
    logic        entering;
    int unsigned scaled;
    r = '0;
    entering = (seq_pend != seq_entered);
    case (ev.action)
      ACT_TICK: begin
        if (seq_ticks != '0) seq_ticks = seq_ticks - 1'b1;
      end
      ACT_INIT: begin
        if (ev.bus_ok) seq_pend = ST_LOAD;
        else r.failed = 1'b1;
      end
      ACT_RUN: begin
        case (seq_pend)
          ST_LOAD: begin
            if (entering) begin
              if (ev.bus_ok) begin
                seq_entered = ST_LOAD;
              end else begin
                seq_pend = ST_ERR;
                r.failed = 1'b1;
              end
            end else begin
              r.bus_op = OP_WRITE;
              if (ev.bus_ok) begin
                seq_ticks = cfg_mode_tmo;
                seq_pend  = ST_WAIT;
              end else begin
                seq_pend = ST_ERR;
                r.failed = 1'b1;
              end
            end
          end
          ST_WAIT: begin
            if (entering) begin
              seq_entered = ST_WAIT;
            end else if (seq_ticks == '0) begin
              r.bus_op = OP_READ;
              if (ev.bus_ok) begin
                seq_lux  = ev.read_data;
                seq_pend = ST_CONV;
              end else begin
                seq_pend = ST_ERR;
                r.failed = 1'b1;
              end
            end
          end
          ST_CONV: begin
            if (entering) begin
              seq_entered = ST_CONV;
            end else begin
              scaled = {16'b0, seq_lux};
              scaled = (scaled * LUX_MUL) / LUX_DIV;
              seq_lux = value_t'(scaled);
              r.lux_valid = 1'b1;
              // continuous modes re-arm, single-shot modes reload the mode
              if (cfg_mode < CONT_LIMIT) begin
                seq_ticks = cfg_meas_tmo;
                seq_pend  = ST_WAIT;
              end else begin
                seq_pend = ST_LOAD;
              end
            end
          end
          default: begin
            // idle and error only adopt the state on entry
            if (entering) seq_entered = seq_pend;
          end
        endcase
      end
      default: ;  // unused action code: no effect
    endcase
    if (r.bus_op != OP_NONE) r.bus_address = cfg_addr;
    if (r.bus_op == OP_WRITE) r.bus_byte = cfg_mode;
    r.state_code = seq_pend;
    r.lux        = seq_lux;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic item_t make_event(action_t act, logic ok, value_t data);
    item_t ev;
    ev.action    = act;
    ev.bus_ok    = ok;
    ev.read_data = data;
    return ev;
  endfunction

  // Mostly the event a healthy poll loop would issue next, some noise
  function automatic item_t next_poll_event();
    item_t ev;
    case ($urandom_range(0, 9))
      0:       ev.read_data = 16'h0000;
      1:       ev.read_data = 16'hFFFF;
      default: ev.read_data = value_t'($urandom_range(0, 65535));
    endcase
    if ($urandom_range(0, 99) < 15) begin
      ev.action = action_t'($urandom_range(0, 3));
      ev.bus_ok = 1'($urandom_range(0, 1));
    end else begin
      ev.bus_ok = ($urandom_range(0, 19) != 0);
      if (seq_pend == ST_IDLE || seq_pend == ST_ERR) begin
        ev.action = ($urandom_range(0, 4) == 0) ? ACT_RUN : ACT_INIT;
      end else if (seq_pend == ST_WAIT && seq_entered == ST_WAIT && seq_ticks != '0) begin
        ev.action = ACT_TICK;
      end else begin
        ev.action = ACT_RUN;
      end
    end
    return ev;
  endfunction

  function automatic tick_t short_timeout();
    if ($urandom_range(0, 3) == 0) return tick_t'($urandom_range(7, 40));
    return tick_t'($urandom_range(0, 6));
  endfunction

  // One event transfer; the expectation is recorded at the accepting edge
  task automatic send_event(item_t ev);
    in_ch.valid     <= 1'b1;
    in_ch.action    <= ev.action;
    in_ch.bus_ok    <= ev.bus_ok;
    in_ch.read_data <= ev.read_data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    step_results_q.push_back(predict_poll_step(ev));
    n_events++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_run(logic ok, value_t data);
    send_event(make_event(ACT_RUN, ok, data));
  endtask

  // Stop offering events and let every outstanding result come back
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (step_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEV_ADDR: cfg_addr     = addr_t'(val);
      CFG_OP_MODE:  cfg_mode     = byte_t'(val);
      CFG_MODE_TMO: cfg_mode_tmo = tick_t'(val);
      CFG_MEAS_TMO: cfg_meas_tmo = tick_t'(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(addr_t addr, byte_t mode, tick_t mode_tmo, tick_t meas_tmo);
    settle_block();
    write_reg(CFG_DEV_ADDR, CDAT_W'(addr));
    write_reg(CFG_OP_MODE,  CDAT_W'(mode));
    write_reg(CFG_MODE_TMO, mode_tmo);
    write_reg(CFG_MEAS_TMO, meas_tmo);
    n_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset configuration: idle run, tick, unused code, failed initialize
  task automatic test_idle_events();
    send_run(1'b1, 16'h0000);
    send_event(make_event(ACT_TICK, 1'b0, 16'h0000));
    send_event(make_event(ACT_UNUSED, 1'b1, 16'hFFFF));
    send_event(make_event(ACT_INIT, 1'b0, 16'hFFFF));
  endtask

  // Continuous mode at the mode limit, zero mode timeout, full-scale read
  task automatic test_continuous_cycle();
    apply_settings(7'd127, 8'h1F, 16'd0, 16'd1);
    send_event(make_event(ACT_INIT, 1'b1, 16'h0000));
    send_run(1'b1, 16'h0000);                // load entry
    send_run(1'b1, 16'h0000);                // mode write
    send_run(1'b1, 16'h0000);                // wait entry
    send_run(1'b1, 16'hFFFF);                // zero timeout: read at once
    send_run(1'b1, 16'h0000);                // convert entry
    send_run(1'b1, 16'h0000);                // scale, re-arm timeout
    send_run(1'b1, 16'h0000);                // wait entry
    send_run(1'b1, 16'h5555);                // timeout not yet elapsed
    send_event(make_event(ACT_TICK, 1'b1, 16'h0000));
    send_event(make_event(ACT_TICK, 1'b1, 16'h0000));  // saturates at zero
    send_run(1'b0, 16'h1234);                // failed read -> error
  endtask

  // Single-shot mode, error state holding, load entry failure
  task automatic test_single_shot_and_errors();
    apply_settings(7'd0, 8'h20, 16'd0, 16'd0);
    send_run(1'b1, 16'h0000);                // error entry
    send_run(1'b1, 16'h0000);                // error holds
    send_event(make_event(ACT_INIT, 1'b1, 16'h0000));
    send_run(1'b1, 16'h0000);
    send_run(1'b1, 16'h0000);
    send_run(1'b1, 16'h0000);
    send_run(1'b1, 16'h8001);
    send_run(1'b1, 16'h0000);
    send_run(1'b1, 16'h0000);                // scale, back to load
    send_run(1'b0, 16'h0000);                // load entry fails
  endtask

  // Receiver holds off while events keep coming, so the block backs up
  task automatic test_backpressure();
    apply_settings(7'd35, 8'h10, 16'd2, 16'd3);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    hold_req  = 1'b1;
    repeat (PRESSURE_EVENTS) send_event(next_poll_event());
    settle_block();
  endtask

  // Randomized poll traffic under a new register setting per phase
  task automatic test_random_polling();
    int    events;
    byte_t mode;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 4))
        0:       mode = 8'h00;
        1:       mode = 8'h1F;
        2:       mode = 8'h20;
        3:       mode = 8'hFF;
        default: mode = byte_t'($urandom_range(0, 255));
      endcase
      if (p == LONG_TMO_PHASE) begin
        apply_settings(addr_t'($urandom_range(0, 127)), mode, 16'hFFFF, 16'hFFFF);
        events = LONG_TMO_EVENTS;
      end else begin
        apply_settings(addr_t'($urandom_range(0, 127)), mode, short_timeout(),
                       short_timeout());
        events = PHASE_EVENTS;
      end
      // every third phase runs without idling, and the last one too
      gaps_on   = (p != RANDOM_PHASES - 1) && (p % 3 != 2);
      stalls_on = gaps_on;
      repeat (events) send_event(next_poll_event());
    end
  endtask

  // --------------------------------------------------------------------------
  // Result receiver with random stalls and the long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 19);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                      logic [VAL_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (step_results_q.size() == 0) begin
        $error("result transfer with no event outstanding");
        n_errors++;
      end else begin
        want = step_results_q.pop_front();
        if (want.lux_valid) n_lux++;
        if (want.failed) n_failed++;
        check_field("bus_op",      VAL_W'(want.bus_op),      VAL_W'(out_ch.bus_op));
        check_field("bus_address", VAL_W'(want.bus_address), VAL_W'(out_ch.bus_address));
        check_field("bus_byte",    VAL_W'(want.bus_byte),    VAL_W'(out_ch.bus_byte));
        check_field("state_code",  VAL_W'(want.state_code),  VAL_W'(out_ch.state_code));
        check_field("lux",         want.lux,                 out_ch.lux);
        check_field("lux_valid",   VAL_W'(want.lux_valid),   VAL_W'(out_ch.lux_valid));
        check_field("failed",      VAL_W'(want.failed),      VAL_W'(out_ch.failed));
      end
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
               quiet_cycles, step_results_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_DEV_ADDR;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_RUN;
    in_ch.bus_ok    <= 1'b0;
    in_ch.read_data <= '0;
    reset_poll_model();
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_events();
    test_continuous_cycle();
    test_single_shot_and_errors();
    test_backpressure();
    test_random_polling();
    settle_block();

    if (step_results_q.size() != 0) begin
      $error("%0d expected results never arrived", step_results_q.size());
      n_errors++;
    end
    $display("Run covered %0d events and %0d results: %0d lux conversions, %0d failed steps.",
             n_events, n_results, n_lux, n_failed);
    $display("Register settings: %0d, plus one %0d-cycle result hold-off.",
             n_settings, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
